// ===== rtl/ipr_pkg.sv =====
// ipr_pkg: shared types and codes for the icmp probe reply filter
// used by ipr_parser, ipr_verdict and icmp_probe_reply_filter; no dependencies

package ipr_pkg;

	// parser phases
	localparam logic [2:0] PH_OUTER      = 3'd0;
	localparam logic [2:0] PH_ICMP       = 3'd1;
	localparam logic [2:0] PH_INNER      = 3'd2;
	localparam logic [2:0] PH_INNER_ICMP = 3'd3;
	localparam logic [2:0] PH_DONE       = 3'd4;
	localparam logic [2:0] PH_WRONG      = 3'd5;
	localparam logic [2:0] PH_BAD        = 3'd6;

	// result status codes
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_WRONG_MSG = 3'd1;
	localparam logic [2:0] ST_ID_MISS   = 3'd2;
	localparam logic [2:0] ST_SEQ_MISS  = 3'd3;
	localparam logic [2:0] ST_TRUNC     = 3'd4;

	// icmp message types
	localparam logic [7:0] ICMP_ECHO_REPLY   = 8'd0;
	localparam logic [7:0] ICMP_TIME_EXCEED  = 8'd11;
	localparam logic [7:0] ICMP_CODE_TTL     = 8'd0;

	// minimum ipv4 header length in words
	localparam logic [3:0] IHL_MIN = 4'd5;

	// configuration register indexes
	localparam logic REG_PROCESS_ID = 1'b0;
	localparam logic REG_PROBE_TTL  = 1'b1;

	typedef struct packed {
		logic [7:0] packet_byte;
		logic       last_byte;
	} ipr_in_t;

	typedef struct packed {
		logic        accepted;
		logic [15:0] sequence_res;
		logic        reply_kind;
		logic [2:0]  status;
	} ipr_out_t;

	// parser state after the current byte, handed to the verdict logic
	typedef struct packed {
		logic [2:0]  phase;
		logic [7:0]  message_type;
		logic [15:0] echo_identifier;
		logic [15:0] echo_sequence;
	} ipr_view_t;

endpackage

// ===== rtl/icmp_probe_reply_filter.sv =====
// icmp_probe_reply_filter: top level, input stage, config registers, result register
// depends on ipr_pkg, ipr_parser, ipr_verdict
//
// usage
//   in channel (in_valid/in_ready/in_data): one packet byte per item, network order,
//   with last_byte set on the final byte of the packet
//   out channel (out_valid/out_ready/out_data): exactly one result item per packet,
//   issued for the byte that carries last_byte
//   cfg port: cfg_we with cfg_index 0 writes process_id, index 1 writes probe_ttl;
//   writes take effect at once and are meant for idle periods between packets
// timing
//   one byte per cycle sustained while no last byte waits for the result slot; a byte is held in
//   the input register and folded into the header walk when it moves on; a last byte moving on
//   also loads the result register, from which the result is shown
// reset
//   arst_n clears the parser to the start of a packet, empties both registers,
//   sets process_id to 0 and probe_ttl to 1
// stall
//   bytes that are not the last never wait; a last byte waits in the input register
//   only while a previous result is still held unread, and in_ready drops then

module icmp_probe_reply_filter import ipr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  ipr_in_t     in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output ipr_out_t    out_data,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_wdata
);

	// configuration
	logic [15:0] process_id_q;
	logic [7:0]  probe_ttl_q;

	// input register
	logic        valid_s1;
	ipr_in_t     data_s1;

	// result register
	logic        out_valid_q;
	ipr_out_t    out_data_q;

	logic        slot_free;
	logic        advance_s1;
	logic        in_take;
	ipr_view_t   view;
	ipr_out_t    result;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			process_id_q <= '0;
			probe_ttl_q  <= 8'd1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PROCESS_ID: process_id_q <= cfg_wdata;
				REG_PROBE_TTL:  probe_ttl_q  <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

	// result slot is free when empty or being read this cycle
	assign slot_free  = !out_valid_q || out_ready;
	// a held byte moves on unless it is the last and the result slot is busy
	assign advance_s1 = valid_s1 && (!data_s1.last_byte || slot_free);
	assign in_ready   = !valid_s1 || advance_s1;
	assign in_take    = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take)
			data_s1 <= in_data;
	end

	ipr_parser u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (advance_s1),
		.packet_byte (data_s1.packet_byte),
		.last_byte   (data_s1.last_byte),
		.view        (view)
	);

	ipr_verdict u_verdict (
		.view       (view),
		.process_id (process_id_q),
		.probe_ttl  (probe_ttl_q),
		.result     (result)
	);

	// one result per packet, loaded when the last byte goes through
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance_s1 && data_s1.last_byte) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1 && data_s1.last_byte)
			out_data_q <= result;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

// ===== rtl/ipr_parser.sv =====
// ipr_parser: per-packet header walk, one byte per enabled cycle
// depends on ipr_pkg

module ipr_parser import ipr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       en,
	input  logic [7:0] packet_byte,
	input  logic       last_byte,
	output ipr_view_t  view
);

	logic [2:0]  phase_q;
	logic [7:0]  byte_idx_q;
	logic [5:0]  outer_len_q;
	logic [5:0]  inner_len_q;
	logic [7:0]  msg_type_q;
	logic [7:0]  msg_code_q;
	logic [15:0] echo_id_q;
	logic [15:0] echo_seq_q;

	logic [2:0]  ph_d;
	logic [5:0]  outer_len_d;
	logic [5:0]  inner_len_d;
	logic [7:0]  msg_type_d;
	logic [7:0]  msg_code_d;
	logic [15:0] echo_id_d;
	logic [15:0] echo_seq_d;
	logic [7:0]  byte_idx_d;
	logic [7:0]  rel_msg;
	logic [7:0]  rel_inner;
	logic [7:0]  rel_echo;
	logic        take_en;
	logic [7:0]  take_rel;

	assign rel_msg   = byte_idx_q - {2'b00, outer_len_q};
	assign rel_inner = rel_msg - 8'd8;
	assign rel_echo  = rel_inner - {2'b00, inner_len_q};
	assign byte_idx_d = (byte_idx_q == 8'hFF) ? byte_idx_q : byte_idx_q + 8'd1;

	always_comb begin
		ph_d        = phase_q;
		outer_len_d = outer_len_q;
		inner_len_d = inner_len_q;
		msg_type_d  = msg_type_q;
		msg_code_d  = msg_code_q;
		echo_id_d   = echo_id_q;
		echo_seq_d  = echo_seq_q;
		take_en     = 1'b0;
		take_rel    = rel_msg;

		// outer header: length nibble, then skip to the message
		if (ph_d == PH_OUTER) begin
			if (byte_idx_q == 8'd0) begin
				outer_len_d = {packet_byte[3:0], 2'b00};
				if (packet_byte[3:0] < IHL_MIN)
					ph_d = PH_BAD;
			end else if (byte_idx_q == {2'b00, outer_len_q}) begin
				ph_d = PH_ICMP;
			end
		end

		// outer icmp header
		if (ph_d == PH_ICMP) begin
			if (rel_msg == 8'd0) begin
				msg_type_d = packet_byte;
			end else if (rel_msg == 8'd1) begin
				msg_code_d = packet_byte;
				if (!(msg_type_q == ICMP_ECHO_REPLY ||
				      (msg_type_q == ICMP_TIME_EXCEED && packet_byte == ICMP_CODE_TTL)))
					ph_d = PH_WRONG;
			end else if (msg_type_q == ICMP_ECHO_REPLY) begin
				take_en  = 1'b1;
				take_rel = rel_msg;
			end else if (rel_msg == 8'd8) begin
				ph_d = PH_INNER;
			end
		end

		// quoted inner ipv4 header
		if (ph_d == PH_INNER) begin
			if (rel_inner == 8'd0) begin
				inner_len_d = {packet_byte[3:0], 2'b00};
				if (packet_byte[3:0] < IHL_MIN)
					ph_d = PH_BAD;
			end else if (rel_inner == {2'b00, inner_len_q}) begin
				ph_d = PH_INNER_ICMP;
			end
		end

		// quoted icmp header
		if (ph_d == PH_INNER_ICMP) begin
			take_en  = 1'b1;
			take_rel = rel_echo;
		end

		// identifier and sequence at header offsets 4 to 7
		if (take_en) begin
			case (take_rel)
				8'd4: echo_id_d  = {packet_byte, 8'h00};
				8'd5: echo_id_d  = {echo_id_q[15:8], packet_byte};
				8'd6: echo_seq_d = {packet_byte, 8'h00};
				8'd7: begin
					echo_seq_d = {echo_seq_q[15:8], packet_byte};
					ph_d       = PH_DONE;
				end
				default: ;
			endcase
		end
	end

	assign view.phase           = ph_d;
	assign view.message_type    = msg_type_d;
	assign view.echo_identifier = echo_id_d;
	assign view.echo_sequence   = echo_seq_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_OUTER;
			byte_idx_q  <= '0;
			outer_len_q <= '0;
			inner_len_q <= '0;
			msg_type_q  <= '0;
			msg_code_q  <= '0;
			echo_id_q   <= '0;
			echo_seq_q  <= '0;
		end else if (en) begin
			if (last_byte) begin
				phase_q     <= PH_OUTER;
				byte_idx_q  <= '0;
				outer_len_q <= '0;
				inner_len_q <= '0;
				msg_type_q  <= '0;
				msg_code_q  <= '0;
				echo_id_q   <= '0;
				echo_seq_q  <= '0;
			end else begin
				phase_q     <= ph_d;
				byte_idx_q  <= byte_idx_d;
				outer_len_q <= outer_len_d;
				inner_len_q <= inner_len_d;
				msg_type_q  <= msg_type_d;
				msg_code_q  <= msg_code_d;
				echo_id_q   <= echo_id_d;
				echo_seq_q  <= echo_seq_d;
			end
		end
	end

endmodule

// ===== rtl/ipr_verdict.sv =====
// ipr_verdict: turns the final parser state into one result item
// depends on ipr_pkg

module ipr_verdict import ipr_pkg::*; (
	input  ipr_view_t   view,
	input  logic [15:0] process_id,
	input  logic [7:0]  probe_ttl,
	output ipr_out_t    result
);

	logic [9:0] ttl_x3;
	logic [9:0] seq_lo;
	logic [9:0] seq_hi;
	logic       seq_hit;
	logic       complete;

	// sequence / 3 == ttl - 1  <=>  3*(ttl-1) <= sequence <= 3*(ttl-1) + 2
	assign ttl_x3  = {1'b0, probe_ttl, 1'b0} + {2'b00, probe_ttl};
	assign seq_lo  = ttl_x3 - 10'd3;
	assign seq_hi  = ttl_x3 - 10'd1;
	assign seq_hit = (probe_ttl != 8'd0) &&
	                 (view.echo_sequence >= {6'b0, seq_lo}) &&
	                 (view.echo_sequence <= {6'b0, seq_hi});
	assign complete = (view.phase == PH_DONE);

	always_comb begin
		result.accepted     = 1'b0;
		result.sequence_res = '0;
		result.reply_kind   = 1'b0;
		if (view.phase == PH_WRONG) begin
			result.status = ST_WRONG_MSG;
		end else if (!complete) begin
			result.status = ST_TRUNC;
		end else begin
			result.reply_kind = (view.message_type == ICMP_ECHO_REPLY);
			if (view.echo_identifier != process_id) begin
				result.status = ST_ID_MISS;
			end else if (!seq_hit) begin
				result.status = ST_SEQ_MISS;
			end else begin
				result.status       = ST_OK;
				result.accepted     = 1'b1;
				result.sequence_res = view.echo_sequence;
			end
		end
	end

endmodule
